// ----- sv/sts_pkg.sv -----
package sts_pkg;

  localparam int MAX_TOKEN_BYTES_DEF = 255;

  // Character codes the scanner looks at
  localparam logic [7:0] CH_SEP_MAX = 8'd32;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_LBRACE  = 8'h7b;
  localparam logic [7:0] CH_RBRACE  = 8'h7d;

  typedef enum logic [5:0] {
    M_SKIP     = 6'b000001,
    M_SLASH    = 6'b000010,
    M_COMMENT  = 6'b000100,
    M_WORD     = 6'b001000,
    M_QUOTE    = 6'b010000,
    M_QUOTE_BS = 6'b100000
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tok_byte;
    logic       has_byte;
    logic       token_end;
    logic       run_last;
  } out_item_t;

  // Up to two results produced by one input byte
  typedef struct packed {
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } res_pair_t;

  function automatic logic is_single(logic [7:0] b);
    return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LPAREN) ||
           (b == CH_RPAREN) || (b == CH_SQUOTE) || (b == CH_COMMA);
  endfunction

endpackage

// ----- sv/script_token_splitter_top.sv -----
// Script token splitter: tokenizes a text buffer streamed one byte per request.
// Input channel: in_valid_i / in_stall_o carry in_item_i (in_byte, is_final).
//   is_final marks the last byte of a buffer; any open token is closed and the
//   scanner goes back to its between-tokens state.
// Output channel: out_valid_o / out_stall_i carry out_item_o. Each request is a
//   token byte (has_byte) and/or a token close (token_end); run_last flags the
//   last result caused by one input byte. Bytes yield zero, one or two results.
// Path: an accepted byte is held in the input register; its results are then
//   loaded into the result pair register, which drives the output channel.
// Throughput: one byte per cycle while out_stall_i is low and each byte yields
//   at most one result; a two-result byte holds the result register for two
//   output transfers. Bytes that yield nothing pass even while output stalls.
// Stall: while out_stall_i is high the current result holds; the result pair
//   register and the input register fill, then in_stall_o rises.
// Reset: clears both channels' valid state and returns the scanner to
//   skipping white space with a token length of zero.
module script_token_splitter_top #(
  parameter int MaxTokenBytes = sts_pkg::MAX_TOKEN_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sts_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sts_pkg::out_item_t out_item_o
);
  import sts_pkg::*;

  localparam int LenW = $clog2(MaxTokenBytes + 1);

  in_item_t        in_q;
  logic            in_vq;
  scan_mode_e      mode_q, mode_d;
  logic [LenW-1:0] len_q, len_d;
  res_pair_t       pair;
  logic            can_load;
  logic            advance;
  logic            load;
  logic            in_acc;

  sts_step #(
    .MaxTokenBytes(MaxTokenBytes)
  ) u_step (
    .item_i (in_q),
    .mode_i (mode_q),
    .len_i  (len_q),
    .pair_o (pair),
    .mode_o (mode_d),
    .len_o  (len_d)
  );

  assign advance    = in_vq && ((pair.n == 2'd0) || can_load);
  assign load       = advance && (pair.n != 2'd0);
  assign in_stall_o = in_vq && !advance;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq  <= 1'b0;
      mode_q <= M_SKIP;
      len_q  <= '0;
    end else begin
      if (in_acc) begin
        in_vq <= 1'b1;
      end else if (advance) begin
        in_vq <= 1'b0;
      end
      if (advance) begin
        mode_q <= mode_d;
        len_q  <= len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_item_i;
    end
  end

  sts_res_buf u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .pair_i      (pair),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- sv/sts_step.sv -----
module sts_step #(
  parameter int MaxTokenBytes = sts_pkg::MAX_TOKEN_BYTES_DEF
) (
  input  sts_pkg::in_item_t   item_i,
  input  sts_pkg::scan_mode_e mode_i,
  input  logic [$clog2(MaxTokenBytes+1)-1:0] len_i,
  output sts_pkg::res_pair_t  pair_o,
  output sts_pkg::scan_mode_e mode_o,
  output logic [$clog2(MaxTokenBytes+1)-1:0] len_o
);
  import sts_pkg::*;

  localparam int LenW = $clog2(MaxTokenBytes + 1);

  typedef struct packed {
    logic [LenW-1:0] len;
    logic [1:0]      n;
    out_item_t       r0;
    out_item_t       r1;
  } acc_t;

  function automatic acc_t f_push(acc_t st, logic [7:0] ch, logic has, logic tend);
    acc_t      r;
    out_item_t x;
    x.tok_byte  = has ? ch : 8'd0;
    x.has_byte  = has;
    x.token_end = tend;
    x.run_last  = 1'b0;
    r = st;
    if (st.n == 2'd0) begin
      r.r0 = x;
    end else if (st.n == 2'd1) begin
      r.r1 = x;
    end
    if (st.n != 2'd2) begin
      r.n = st.n + 2'd1;
    end
    return r;
  endfunction

  // Bytes past the length limit are dropped
  function automatic acc_t f_emit(acc_t st, logic [7:0] ch);
    acc_t r;
    r = st;
    if (st.len < LenW'(MaxTokenBytes)) begin
      r = f_push(st, ch, 1'b1, 1'b0);
      r.len = st.len + LenW'(1);
    end
    return r;
  endfunction

  // Close marks the last open result, or adds an empty closing result
  function automatic acc_t f_close(acc_t st);
    acc_t r;
    r = st;
    if (st.n == 2'd1 && !st.r0.token_end) begin
      r.r0.token_end = 1'b1;
    end else if (st.n == 2'd2 && !st.r1.token_end) begin
      r.r1.token_end = 1'b1;
    end else begin
      r = f_push(st, 8'd0, 1'b0, 1'b1);
    end
    r.len = '0;
    return r;
  endfunction

  function automatic acc_t f_word(acc_t st, logic [7:0] ch);
    acc_t r;
    r = st;
    if (is_single(ch)) begin
      r = f_close(r);
      r = f_emit(r, ch);
      r = f_close(r);
    end else if (ch <= CH_SEP_MAX) begin
      r = f_close(r);
    end else begin
      r = f_emit(r, ch);
    end
    return r;
  endfunction

  logic [7:0] b;
  logic       word_ends;
  acc_t       a;
  scan_mode_e m;

  assign b = item_i.in_byte;
  assign word_ends = is_single(b) || (b <= CH_SEP_MAX);

  always_comb begin
    a.len = len_i;
    a.n   = 2'd0;
    a.r0  = '0;
    a.r1  = '0;
    m     = mode_i;
    unique case (mode_i)
      M_SKIP: begin
        if (b <= CH_SEP_MAX) begin
          m = M_SKIP;
        end else if (b == CH_SLASH) begin
          m = M_SLASH;
        end else if (b == CH_DQUOTE) begin
          a.len = '0;
          m = M_QUOTE;
        end else if (is_single(b)) begin
          a.len = '0;
          a = f_emit(a, b);
          a = f_close(a);
          m = M_SKIP;
        end else begin
          a.len = '0;
          a = f_emit(a, b);
          m = M_WORD;
        end
      end
      M_SLASH: begin
        if (b == CH_SLASH) begin
          m = M_COMMENT;
        end else begin
          a.len = '0;
          a = f_emit(a, CH_SLASH);
          a = f_word(a, b);
          m = word_ends ? M_SKIP : M_WORD;
        end
      end
      M_COMMENT: begin
        if (b == CH_NEWLINE) begin
          m = M_SKIP;
        end
      end
      M_WORD: begin
        a = f_word(a, b);
        m = word_ends ? M_SKIP : M_WORD;
      end
      M_QUOTE: begin
        if (b == CH_BSLASH) begin
          m = M_QUOTE_BS;
        end else if (b == CH_DQUOTE) begin
          a = f_close(a);
          m = M_SKIP;
        end else begin
          a = f_emit(a, b);
        end
      end
      M_QUOTE_BS: begin
        if (b == CH_DQUOTE) begin
          a = f_emit(a, CH_DQUOTE);
          m = M_QUOTE;
        end else begin
          a = f_emit(a, CH_BSLASH);
          if (b == CH_BSLASH) begin
            m = M_QUOTE_BS;
          end else begin
            a = f_emit(a, b);
            m = M_QUOTE;
          end
        end
      end
      default: begin
        m = M_SKIP;
      end
    endcase

    // End of buffer: flush whatever token is still open
    if (item_i.is_final) begin
      if (m == M_SLASH) begin
        a.len = '0;
        a = f_emit(a, CH_SLASH);
        a = f_close(a);
      end else if (m == M_QUOTE_BS) begin
        a = f_emit(a, CH_BSLASH);
        a = f_close(a);
      end else if (m == M_WORD || m == M_QUOTE) begin
        a = f_close(a);
      end
      m = M_SKIP;
      a.len = '0;
    end

    if (a.n == 2'd1) begin
      a.r0.run_last = 1'b1;
    end
    if (a.n == 2'd2) begin
      a.r1.run_last = 1'b1;
    end
  end

  assign pair_o.n  = a.n;
  assign pair_o.r0 = a.r0;
  assign pair_o.r1 = a.r1;
  assign mode_o    = m;
  assign len_o     = a.len;

endmodule

// ----- sv/sts_res_buf.sv -----
module sts_res_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  sts_pkg::res_pair_t  pair_i,
  output logic                can_load_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sts_pkg::out_item_t  out_item_o
);
  import sts_pkg::*;

  out_item_t  slot0_q, slot1_q;
  logic [1:0] rem_q, rem_d;
  logic       head_q, head_d;
  logic       out_acc;

  assign out_valid_o = (rem_q != 2'd0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign out_item_o  = head_q ? slot1_q : slot0_q;
  // Room for a new pair when none is pending or the last pending result leaves this cycle
  assign can_load_o  = (rem_q == 2'd0) || ((rem_q == 2'd1) && out_acc);

  always_comb begin
    rem_d  = rem_q;
    head_d = head_q;
    if (load_i) begin
      rem_d  = pair_i.n;
      head_d = 1'b0;
    end else if (out_acc) begin
      rem_d  = rem_q - 2'd1;
      head_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= 2'd0;
      head_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot0_q <= pair_i.r0;
      slot1_q <= pair_i.r1;
    end
  end

endmodule

// ----- sv/sts_checker.sv -----
module sts_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input sts_pkg::out_item_t out_item_o
);

  // A result is either a token byte or a bare close, never an empty no-op
  a_empty_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.has_byte) |-> out_item_o.token_end)
    else $error("result without byte does not close a token");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.has_byte) |-> (out_item_o.tok_byte == 8'd0))
    else $error("result without byte carries nonzero data");

  // A stall on the input side is only caused by pending output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_stall_o && !$past(in_stall_o) && $past(rst_ni)) |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

endmodule

bind script_token_splitter_top sts_checker u_sts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
